### sv/tiling_layout_rect_generator_assert.svh
// Assertion macros for the layout generator. Empty when synthesizing.
`ifndef TILING_LAYOUT_RECT_GENERATOR_ASSERT_SVH
`define TILING_LAYOUT_RECT_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TLRG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlrg: same-cycle check failed");
`define TLRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlrg: next-cycle check failed");
`else
`define TLRG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TLRG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/tlrg_pkg.sv
package tlrg_pkg;

   localparam int MAX_CLIENTS      = 64;
   localparam int WIDE_FIXED_WIDTH = 524;
   localparam int THIN_FIXED_WIDTH = 260;
   localparam int FIXED_MARGIN     = 10;
   localparam int DIV_W            = 16;
   localparam int CNT_W            = 7;

   localparam logic signed [15:0] RST_AREA_X    = 16'sd0;
   localparam logic signed [15:0] RST_AREA_Y    = 16'sd0;
   localparam logic [15:0]        RST_AREA_W    = 16'd1920;
   localparam logic [15:0]        RST_AREA_H    = 16'd1080;
   localparam logic [15:0]        RST_MONITOR_W = 16'd1920;
   localparam logic [15:0]        RST_MONITOR_H = 16'd1080;
   localparam logic [6:0]         RST_MASTER_CNT = 7'd1;
   localparam logic [15:0]        RST_MASTER_FRAC = 16'd36045;

   typedef enum logic [1:0] {
      ACT_BOTTOM_STACK,
      ACT_RIGHT_STACK,
      ACT_WIDE_FIXED,
      ACT_THIN_FIXED
   } tlrg_action_type;

   typedef enum logic [2:0] {
      CSR_AREA_X,
      CSR_AREA_Y,
      CSR_AREA_W,
      CSR_AREA_H,
      CSR_MONITOR_W,
      CSR_MONITOR_H,
      CSR_MASTER_COUNT,
      CSR_MASTER_FRACTION
   } tlrg_csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV_M,
      BK_DIV_S,
      BK_EMIT
   } tlrg_back_state_type;

   typedef enum logic [1:0] {
      SEG_FIX,
      SEG_MAST,
      SEG_STACK
   } tlrg_seg_type;

   typedef struct packed {
      tlrg_action_type action;
      logic [6:0]      client_count;
      logic [7:0]      border_width;
   } tlrg_req_type;

   typedef struct packed {
      logic [5:0]         client_index;
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic [15:0]        rect_w;
      logic [15:0]        rect_h;
      logic               last;
   } tlrg_rsp_type;

   typedef struct packed {
      logic signed [15:0] area_x;
      logic signed [15:0] area_y;
      logic [15:0]        area_w;
      logic [15:0]        area_h;
      logic [15:0]        monitor_w;
      logic [15:0]        monitor_h;
      logic [6:0]         master_count;
      logic [15:0]        master_fraction;
   } tlrg_cfg_type;

   // classified request as queued between front and back
   typedef struct packed {
      tlrg_action_type  action;
      logic [7:0]       border_width;
      logic [15:0]      wfix;
      logic [CNT_W-1:0] n_mast;
      logic [CNT_W-1:0] n_stack;
   } tlrg_job_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } tlrg_div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } tlrg_div_rsp_type;

   typedef struct packed {
      logic emitting;
      logic div_wait;
   } tlrg_back_status_type;

endpackage

### sv/tlrg_front.sv
module tlrg_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tlrg_pkg::tlrg_req_type req_payload,
   input  tlrg_pkg::tlrg_cfg_type cfg,
   input  logic                  queue_full,
   output logic                  job_push,
   output tlrg_pkg::tlrg_job_type job
);
   import tlrg_pkg::*;

   logic [CNT_W-1:0] n_clamp;
   logic [CNT_W-1:0] n_region;
   logic [CNT_W-1:0] n_mast;
   logic             fixed_mode;
   logic [16:0]      want;
   logic [15:0]      lim;

   assign req_ready  = !queue_full;
   assign fixed_mode = (req_payload.action == ACT_WIDE_FIXED) ||
                       (req_payload.action == ACT_THIN_FIXED);

   always_comb begin
      n_clamp  = (req_payload.client_count > CNT_W'(MAX_CLIENTS)) ?
                 CNT_W'(MAX_CLIENTS) : req_payload.client_count;
      // fixed modes spend client 0 on the left column
      n_region = fixed_mode ? n_clamp - 1'b1 : n_clamp;
      n_mast   = (cfg.master_count < n_region) ? cfg.master_count : n_region;
      want     = ((req_payload.action == ACT_WIDE_FIXED) ? 17'(WIDE_FIXED_WIDTH) :
                                                           17'(THIN_FIXED_WIDTH)) +
                 17'({req_payload.border_width, 1'b0});
      lim      = (cfg.area_w < 16'(FIXED_MARGIN)) ? 16'd0 :
                 cfg.area_w - 16'(FIXED_MARGIN);
   end

   // an empty request is taken and dropped here
   assign job_push = req_valid && !queue_full && (n_clamp != '0);

   always_comb begin
      job.action       = req_payload.action;
      job.border_width = req_payload.border_width;
      job.wfix         = ({1'b0, lim} < want) ? lim : want[15:0];
      job.n_mast       = n_mast;
      job.n_stack      = n_region - n_mast;
   end

endmodule

### sv/tlrg_fifo.sv
module tlrg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### sv/tlrg_divider.sv
module tlrg_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  tlrg_pkg::tlrg_div_req_type div_req,
   output tlrg_pkg::tlrg_div_rsp_type div_rsp
);
   import tlrg_pkg::*;

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   diff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIV_W);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         step_in = step_ff - 1'b1;
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### sv/tlrg_back.sv
module tlrg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  tlrg_pkg::tlrg_cfg_type         cfg,
   input  logic                          queue_empty,
   input  tlrg_pkg::tlrg_job_type         job_head,
   output logic                          queue_pop,
   output tlrg_pkg::tlrg_div_req_type     div_req,
   input  tlrg_pkg::tlrg_div_rsp_type     div_rsp,
   output tlrg_pkg::tlrg_back_status_type status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tlrg_pkg::tlrg_rsp_type         rsp_payload
);
   import tlrg_pkg::*;

   function automatic logic [15:0] fit_size(input logic signed [18:0] v,
                                            input logic [7:0] bw);
      logic signed [18:0] s;
      s = v - $signed({10'b0, bw, 1'b0});
      if (s < 0) begin
         return 16'd0;
      end else if (s > $signed(19'h0FFFF)) begin
         return 16'hFFFF;
      end
      return s[15:0];
   endfunction

   tlrg_back_state_type state_ff, state_in;
   tlrg_job_type        job_ff;
   tlrg_seg_type        seg_ff, seg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [15:0]         acc_ff, acc_in;
   logic [5:0]          idx_ff;
   logic [15:0]         share_ff;
   logic [DIV_W-1:0]    q_mast_ff;
   logic [DIV_W-1:0]    q_stack_ff;
   logic                rsp_valid_ff;
   tlrg_rsp_type        rsp_ff;

   logic               fixed_mode, rstack;
   logic               has_mast, has_stack;
   logic               emit_fire, is_last, seg_end;
   logic [31:0]        product;
   logic [15:0]        x0;
   logic [15:0]        rx, ry;
   logic signed [18:0] wv, hv;
   logic signed [18:0] stk_base, stk_lim, stk_span;
   logic signed [18:0] share_s;
   logic signed [18:0] pos_s;
   tlrg_seg_type       seg_first;

   assign fixed_mode = (job_ff.action == ACT_WIDE_FIXED) ||
                       (job_ff.action == ACT_THIN_FIXED);
   assign rstack     = (job_ff.action == ACT_RIGHT_STACK);
   assign has_mast   = (job_ff.n_mast != '0);
   assign has_stack  = (job_ff.n_stack != '0);

   assign product = cfg.master_fraction * (rstack ? cfg.area_w : cfg.area_h);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            if (has_mast) begin
               state_in = BK_DIV_M;
            end else if (has_stack) begin
               state_in = BK_DIV_S;
            end else begin
               state_in = BK_EMIT;
            end
         end
         BK_DIV_M: begin
            if (div_rsp.done) begin
               state_in = has_stack ? BK_DIV_S : BK_EMIT;
            end
         end
         BK_DIV_S: begin
            if (div_rsp.done) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (emit_fire && is_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // ---------------- state outputs ----------------
   always_comb begin
      queue_pop       = 1'b0;
      emit_fire       = 1'b0;
      div_req.start   = 1'b0;
      div_req.divisor = job_ff.n_mast;
      div_req.dividend = rstack ? cfg.area_h :
                         cfg.area_w - (fixed_mode ? job_ff.wfix : 16'd0);
      unique case (state_ff)
         BK_IDLE: queue_pop = !queue_empty;
         BK_MUL: begin
            div_req.start   = has_mast || has_stack;
            div_req.divisor = has_mast ? job_ff.n_mast : job_ff.n_stack;
         end
         BK_DIV_M: begin
            div_req.start   = div_rsp.done && has_stack;
            div_req.divisor = job_ff.n_stack;
         end
         BK_DIV_S: ;
         BK_EMIT: emit_fire = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // ---------------- rectangle of the current client ----------------
   always_comb begin
      share_s  = $signed({3'b0, share_ff});
      pos_s    = rstack ? $signed({{3{cfg.area_x[15]}}, cfg.area_x}) :
                          $signed({{3{cfg.area_y[15]}}, cfg.area_y});
      stk_base = pos_s + (has_mast ? share_s : 19'sd0);
      stk_lim  = $signed({3'b0, rstack ? cfg.monitor_w : cfg.monitor_h});
      // stack extent runs to the monitor edge when masters exist
      stk_span = has_mast ? stk_lim - stk_base :
                            $signed({3'b0, rstack ? cfg.area_w : cfg.area_h});
      x0       = cfg.area_x + (fixed_mode ? job_ff.wfix : 16'd0);
      rx       = cfg.area_x;
      ry       = cfg.area_y;
      wv       = $signed({3'b0, cfg.area_w});
      hv       = $signed({3'b0, cfg.area_h});
      unique case (seg_ff)
         SEG_FIX: begin
            if (has_mast || has_stack) begin
               wv = $signed({3'b0, job_ff.wfix});
            end
         end
         SEG_MAST: begin
            if (rstack) begin
               ry = cfg.area_y + acc_ff;
               wv = $signed({3'b0, has_stack ? share_ff : cfg.area_w});
               hv = $signed({3'b0, q_mast_ff});
            end else begin
               rx = x0 + acc_ff;
               wv = $signed({3'b0, q_mast_ff});
               hv = $signed({3'b0, has_stack ? share_ff : cfg.area_h});
            end
         end
         SEG_STACK: begin
            if (rstack) begin
               rx = stk_base[15:0];
               ry = cfg.area_y + acc_ff;
               wv = stk_span;
               hv = $signed({3'b0, q_stack_ff});
            end else begin
               rx = x0 + acc_ff;
               ry = stk_base[15:0];
               wv = $signed({3'b0, q_stack_ff});
               hv = stk_span;
            end
         end
         default: ;
      endcase
   end

   // ---------------- segment walk ----------------
   always_comb begin
      unique case (seg_ff)
         SEG_FIX:   seg_end = 1'b1;
         SEG_MAST:  seg_end = (cnt_ff + 1'b1 == job_ff.n_mast);
         SEG_STACK: seg_end = (cnt_ff + 1'b1 == job_ff.n_stack);
         default:   seg_end = 1'b1;
      endcase
      unique case (seg_ff)
         SEG_FIX:   is_last = !has_mast && !has_stack;
         SEG_MAST:  is_last = seg_end && !has_stack;
         SEG_STACK: is_last = seg_end;
         default:   is_last = 1'b1;
      endcase
      // first segment of the request being loaded from the queue head
      seg_first = ((job_head.action == ACT_WIDE_FIXED) ||
                   (job_head.action == ACT_THIN_FIXED)) ? SEG_FIX :
                  ((job_head.n_mast != '0) ? SEG_MAST : SEG_STACK);
      seg_in = seg_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      if (queue_pop) begin
         seg_in = seg_first;
         cnt_in = '0;
         acc_in = '0;
      end else if (emit_fire) begin
         if (seg_end) begin
            seg_in = (seg_ff == SEG_FIX && has_mast) ? SEG_MAST : SEG_STACK;
            cnt_in = '0;
            acc_in = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            acc_in = acc_ff + ((seg_ff == SEG_MAST) ? q_mast_ff : q_stack_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         seg_ff       <= SEG_FIX;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         if (queue_pop) begin
            idx_ff <= '0;
         end else if (emit_fire) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         job_ff <= job_head;
      end
      if (state_ff == BK_MUL) begin
         share_ff <= product[31:16];
      end
      if (state_ff == BK_DIV_M && div_rsp.done) begin
         q_mast_ff <= div_rsp.quotient;
      end
      if (state_ff == BK_DIV_S && div_rsp.done) begin
         q_stack_ff <= div_rsp.quotient;
      end
      if (emit_fire) begin
         rsp_ff.client_index <= idx_ff;
         rsp_ff.rect_x       <= rx;
         rsp_ff.rect_y       <= ry;
         rsp_ff.rect_w       <= fit_size(wv, job_ff.border_width);
         rsp_ff.rect_h       <= fit_size(hv, job_ff.border_width);
         rsp_ff.last         <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;
   assign status.emitting = (state_ff == BK_EMIT);
   assign status.div_wait = (state_ff == BK_DIV_M) || (state_ff == BK_DIV_S);

endmodule

### sv/tiling_layout_rect_generator.sv
// Master/stack tiling layout generator. A request (mode, client count, border
// width) is classified on entry and queued; up to QUEUE_DEPTH requests wait
// while an earlier one is laid out. Each request is loaded from the queue and
// its master share product formed, then at most two divisions of the area
// extent by a client count run in the shared bit-serial divider, then the
// rectangles leave the output register one per cycle unless rsp_ready holds
// them back.
// Rectangles leave in client order with last set on the final one; a request
// with zero clients is taken and produces nothing. The user must write registers
// through the csr port only while the block is idle; the block does not enforce it.
`include "tiling_layout_rect_generator_assert.svh"
module tiling_layout_rect_generator #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tlrg_pkg::tlrg_req_type        req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tlrg_pkg::tlrg_rsp_type        rsp_payload,
   input  logic                         csr_wr_en,
   input  tlrg_pkg::tlrg_csr_index_type  csr_index,
   input  logic [15:0]                  csr_wdata
);
   import tlrg_pkg::*;

   tlrg_cfg_type         cfg_ff;
   tlrg_job_type         job_new, job_head;
   tlrg_div_req_type     div_req;
   tlrg_div_rsp_type     div_rsp;
   tlrg_back_status_type back_status;
   logic                 job_push, job_pop, queue_full, queue_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.area_x          <= RST_AREA_X;
         cfg_ff.area_y          <= RST_AREA_Y;
         cfg_ff.area_w          <= RST_AREA_W;
         cfg_ff.area_h          <= RST_AREA_H;
         cfg_ff.monitor_w       <= RST_MONITOR_W;
         cfg_ff.monitor_h       <= RST_MONITOR_H;
         cfg_ff.master_count    <= RST_MASTER_CNT;
         cfg_ff.master_fraction <= RST_MASTER_FRAC;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_AREA_X:          cfg_ff.area_x          <= csr_wdata;
            CSR_AREA_Y:          cfg_ff.area_y          <= csr_wdata;
            CSR_AREA_W:          cfg_ff.area_w          <= csr_wdata;
            CSR_AREA_H:          cfg_ff.area_h          <= csr_wdata;
            CSR_MONITOR_W:       cfg_ff.monitor_w       <= csr_wdata;
            CSR_MONITOR_H:       cfg_ff.monitor_h       <= csr_wdata;
            CSR_MASTER_COUNT:    cfg_ff.master_count    <= csr_wdata[6:0];
            CSR_MASTER_FRACTION: cfg_ff.master_fraction <= csr_wdata;
            default: ;
         endcase
      end
   end

   tlrg_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .queue_full  (queue_full),
      .job_push    (job_push),
      .job         (job_new)
   );

   tlrg_fifo #(
      .WIDTH ($bits(tlrg_job_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_new),
      .full  (queue_full),
      .pop   (job_pop),
      .dout  (job_head),
      .empty (queue_empty)
   );

   tlrg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   tlrg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .job_head    (job_head),
      .queue_pop   (job_pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .status      (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // a quotient only arrives while the back end waits for it
   `TLRG_ASSERT_IMPL(a_div_done_expected, clock, reset, div_rsp.done, back_status.div_wait)
   // never restart the divider mid-division
   `TLRG_ASSERT_IMPL(a_div_start_free, clock, reset, div_req.start, !div_rsp.busy)
   // a rectangle taken without last set leaves the back end still emitting
   `TLRG_ASSERT_IMPL(a_more_follow, clock, reset,
      rsp_valid && rsp_ready && !rsp_payload.last, back_status.emitting)
   // an empty output register is filled at once while emitting
   `TLRG_ASSERT_NEXT(a_emit_fills, clock, reset,
      back_status.emitting && !rsp_valid, rsp_valid)

endmodule
